[src/hamming_encoder_defines.svh]
// Assertion macros shared by the Hamming encoder RTL.
`ifndef HAMMING_ENCODER_DEFINES_SVH
`define HAMMING_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and switched off while reset is low.
`define HME_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and switched off while reset is low.
`define HME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hme_pkg.sv]
// Types, constants and helper functions shared by the Hamming encoder modules.
`default_nettype none

package hme_pkg;

    localparam int LEN_W      = 5;
    localparam int PCNT_W     = 3;
    localparam int CLEN_W     = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LEN_W-1:0] DATA_LENGTH_RESET = 5'd4;
    localparam logic             PARITY_ODD_RESET  = 1'b0;

    // Register index, taken from the word address.
    localparam logic REG_DATA_LENGTH = 1'b0;
    localparam logic REG_PARITY_ODD  = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [PCNT_W-1:0] pcount;
        logic [CLEN_W-1:0] code_len;
        logic              odd;
    } t_cfg;

    // Least p with 2^p >= len + p + 1.
    function automatic int parity_bits_for(int len);
        int p;
        p = 0;
        for (int q = 0; q < 7; q++) begin
            if ((1 << p) < len + p + 1) begin
                p = p + 1;
            end
        end
        return p;
    endfunction

    function automatic bit is_pow2(int pos);
        return (pos & (pos - 1)) == 0;
    endfunction

    // Order of the data bit held at a non-power-of-two Hamming position.
    function automatic int data_index(int pos);
        int lg;
        lg = 0;
        for (int b = 0; b < 7; b++) begin
            if ((pos >> b) > 1) begin
                lg = b + 1;
            end
        end
        return pos - lg - 2;
    endfunction

    // A length of zero counts as one; lengths beyond the build limit saturate.
    function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] raw, int max_len);
        logic [LEN_W-1:0] len;
        len = raw;
        if (raw == '0) begin
            len = LEN_W'(1);
        end else if (int'(raw) > max_len) begin
            len = LEN_W'(max_len);
        end
        return len;
    endfunction

    function automatic t_cfg derive_cfg(logic [LEN_W-1:0] raw, logic odd, int max_len);
        t_cfg c;
        int   len;
        int   p;
        len        = int'(eff_len(raw, max_len));
        p          = parity_bits_for(len);
        c.len      = LEN_W'(len);
        c.pcount   = PCNT_W'(p);
        c.code_len = CLEN_W'(len + p);
        c.odd      = odd;
        return c;
    endfunction

endpackage

`default_nettype wire

[src/hme_cfg.sv]
// Configuration registers of the Hamming encoder behind an APB-style port.
`default_nettype none

module hme_cfg
    import hme_pkg::*;
#(
    parameter int MAX_DATA_BITS = 26
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic [LEN_W-1:0] r_data_length;
    logic             r_parity_odd;
    t_cfg             r_cfg;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    // The derived length and parity count are worked out as the register is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_length <= DATA_LENGTH_RESET;
            r_parity_odd  <= PARITY_ODD_RESET;
            r_cfg         <= derive_cfg(DATA_LENGTH_RESET, PARITY_ODD_RESET, MAX_DATA_BITS);
        end else if (wr_en) begin
            case (reg_idx)
                REG_DATA_LENGTH: begin
                    r_data_length <= pwdata[LEN_W-1:0];
                    r_cfg         <= derive_cfg(pwdata[LEN_W-1:0], r_parity_odd, MAX_DATA_BITS);
                end
                REG_PARITY_ODD: begin
                    r_parity_odd <= pwdata[0];
                    r_cfg.odd    <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DATA_LENGTH: prdata = APB_DATA_W'(r_data_length);
            REG_PARITY_ODD:  prdata = APB_DATA_W'(r_parity_odd);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/hme_enc.sv]
// Combinational Hamming encoding of one data word: bit placement and parity trees.
`default_nettype none

module hme_enc
    import hme_pkg::*;
#(
    parameter  int MAX_DATA_BITS = 26,
    localparam int MAX_LEN       = (MAX_DATA_BITS < 31) ? MAX_DATA_BITS : 31,
    localparam int PMAX          = parity_bits_for(MAX_LEN),
    localparam int CW            = MAX_LEN + PMAX
) (
    input  wire logic [MAX_DATA_BITS-1:0] i_data,
    input  wire t_cfg                     i_cfg,
    output logic      [CW-1:0]            o_codeword
);

    localparam int SH_W    = $clog2(MAX_DATA_BITS + 1);

    logic [MAX_DATA_BITS-1:0] rev;
    logic [MAX_DATA_BITS-1:0] aligned;
    logic [SH_W-1:0]          shamt;
    logic [CW-1:0]            data_code;
    logic [PMAX-1:0]          par;

    // Reversing the word and shifting it down by (max - length) puts the
    // highest used input bit at index 0, the first data slot.
    always_comb begin
        for (int s = 0; s < MAX_DATA_BITS; s++) begin
            rev[MAX_DATA_BITS-1-s] = i_data[s];
        end
        shamt   = SH_W'(MAX_DATA_BITS) - SH_W'(i_cfg.len);
        aligned = rev >> shamt;
    end

    for (genvar pos = 1; pos <= CW; pos++) begin : g_slot
        if (is_pow2(pos)) begin : g_par_slot
            assign data_code[pos-1] = 1'b0;
        end else begin : g_data_slot
            localparam int K = data_index(pos);
            assign data_code[pos-1] = (int'(i_cfg.len) > K) ? aligned[K] : 1'b0;
        end
    end

    // Unused data slots are already zero, so each tree may span the full width.
    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < PMAX; i++) begin
            acc = i_cfg.odd;
            for (int pos = 1; pos <= CW; pos++) begin
                if (((pos >> i) & 1) != 0) begin
                    acc = acc ^ data_code[pos-1];
                end
            end
            par[i] = (i < int'(i_cfg.pcount)) ? acc : 1'b0;
        end
    end

    always_comb begin
        o_codeword = data_code;
        for (int i = 0; i < PMAX; i++) begin
            o_codeword[(1 << i) - 1] = par[i];
        end
    end

endmodule

`default_nettype wire

[src/hamming_encoder.sv]
// Hamming encoder top level: configuration port, input register, encoder and result register.
`default_nettype none
`include "hamming_encoder_defines.svh"

// Encodes one data word per transaction into a Hamming codeword of up to
// 31 bits at the default build, with parity bits at the power-of-two
// positions and data bits filling the rest, highest used input bit first.
// A word can be accepted in every clock cycle unless the input side stalls;
// its result is presented once the word has passed from the input register
// through the XOR trees into the result register. The input side stalls
// only when both registers hold words and the result is being held off.
// The data length and parity sense are set over the APB port, at byte
// addresses 0 and 4, and should only be changed while no word is in flight.

module hamming_encoder
    import hme_pkg::*;
#(
    parameter  int MAX_DATA_BITS = 26,
    localparam int MAX_LEN       = (MAX_DATA_BITS < 31) ? MAX_DATA_BITS : 31,
    localparam int PMAX          = parity_bits_for(MAX_LEN),
    localparam int CW            = MAX_LEN + PMAX,
    localparam int CL_W          = $clog2(CW + 1),
    localparam int PC_W          = $clog2(PMAX + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [APB_ADDR_W-1:0]         paddr,
    input  wire logic [APB_DATA_W-1:0]         pwdata,
    output logic      [APB_DATA_W-1:0]         prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [MAX_DATA_BITS-1:0]      i_data_bits,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [CW-1:0]                 o_codeword,
    output logic      [CL_W-1:0]               o_code_length,
    output logic      [PC_W-1:0]               o_parity_count
);

    t_cfg                     cfg;
    logic                     r_s1_valid;
    logic [MAX_DATA_BITS-1:0] r_s1_data;
    logic                     r_out_valid;
    logic [CW-1:0]            r_codeword;
    logic [CL_W-1:0]          r_code_length;
    logic [PC_W-1:0]          r_parity_count;
    logic [CW-1:0]            enc_codeword;
    logic                     out_free;
    logic                     in_take;
    logic                     out_load;

    hme_cfg #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    hme_enc #(
        .MAX_DATA_BITS(MAX_DATA_BITS)
    ) u_enc (
        .i_data    (r_s1_data),
        .i_cfg     (cfg),
        .o_codeword(enc_codeword)
    );

    // The result register frees up when it is empty or its transaction completes.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_load   = r_s1_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data <= i_data_bits;
        end
        if (out_load) begin
            r_codeword     <= enc_codeword;
            r_code_length  <= CL_W'(cfg.code_len);
            r_parity_count <= PC_W'(cfg.pcount);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_codeword     = r_codeword;
    assign o_code_length  = r_code_length;
    assign o_parity_count = r_parity_count;

    `HME_ASSERT_IMPLY(a_stall_only_full, o_in_stall, r_s1_valid && r_out_valid, "input stalled with a free stage")
    `HME_ASSERT_NEXT(a_s1_held, r_s1_valid && o_in_stall, $stable(r_s1_data), "held input word overwritten")
    `HME_ASSERT_IMPLY(a_upper_zero, o_out_valid, (o_codeword >> o_code_length) == '0, "codeword bits set beyond code length")
    `HME_ASSERT_IMPLY(a_pcount_fits, o_out_valid, (32'd1 << o_parity_count) > 32'(o_code_length), "parity count too small for code length")

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the Hamming encoder: directed table, random phases, APB set-up.
module tb;
    import hme_pkg::*;

    localparam int DATA_W = 26;
    localparam int CODE_W = 31;
    localparam int DIRECTED_ROWS = 21;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct packed {
        logic [CODE_W-1:0] codeword;
        logic [4:0]        code_length;
        logic [2:0]        parity_count;
    } t_code_result;

    typedef struct packed {
        logic [4:0]        len;
        logic              odd;
        logic [DATA_W-1:0] data;
        logic              typed;
        t_code_result      result;
    } t_stim_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [DATA_W-1:0]       i_data_bits = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [CODE_W-1:0]       o_codeword;
    logic [4:0]              o_code_length;
    logic [2:0]              o_parity_count;

    t_code_result pending_codes[$];
    int           mismatch_count = 0;
    logic [4:0]   cur_len = DATA_LENGTH_RESET;
    logic         cur_odd = PARITY_ODD_RESET;
    bit           rx_idle = 1'b0;
    int           rx_hold_cycles = 0;
    int           rx_stall_left = 0;

    // Rows with the typed flag set carry a result that can be worked out by hand.
    t_stim_row directed_rows [0:DIRECTED_ROWS-1] = '{
        '{5'd4,  1'b0, 26'h0000000, 1'b1, '{31'h00000000, 5'd7,  3'd3}},
        '{5'd4,  1'b0, 26'h000000F, 1'b1, '{31'h0000007F, 5'd7,  3'd3}},
        '{5'd4,  1'b0, 26'h0000008, 1'b1, '{31'h00000007, 5'd7,  3'd3}},
        '{5'd4,  1'b0, 26'h0000001, 1'b1, '{31'h0000004B, 5'd7,  3'd3}},
        '{5'd4,  1'b0, 26'h3FFFFF0, 1'b1, '{31'h00000000, 5'd7,  3'd3}},
        '{5'd4,  1'b1, 26'h0000000, 1'b1, '{31'h0000000B, 5'd7,  3'd3}},
        '{5'd4,  1'b1, 26'h000000F, 1'b0, '0},
        '{5'd0,  1'b1, 26'h0000000, 1'b1, '{31'h00000003, 5'd3,  3'd2}},
        '{5'd0,  1'b0, 26'h3FFFFFF, 1'b1, '{31'h00000007, 5'd3,  3'd2}},
        '{5'd1,  1'b0, 26'h3FFFFFE, 1'b1, '{31'h00000000, 5'd3,  3'd2}},
        '{5'd26, 1'b0, 26'h3FFFFFF, 1'b1, '{31'h7FFFFFFF, 5'd31, 3'd5}},
        '{5'd26, 1'b0, 26'h0000000, 1'b1, '{31'h00000000, 5'd31, 3'd5}},
        '{5'd26, 1'b0, 26'h2AAAAAA, 1'b0, '0},
        '{5'd26, 1'b0, 26'h1555555, 1'b0, '0},
        '{5'd26, 1'b1, 26'h0000000, 1'b1, '{31'h0000808B, 5'd31, 3'd5}},
        '{5'd26, 1'b1, 26'h3FFFFFF, 1'b0, '0},
        '{5'd31, 1'b0, 26'h3FFFFFF, 1'b1, '{31'h7FFFFFFF, 5'd31, 3'd5}},
        '{5'd27, 1'b1, 26'h2AAAAAA, 1'b0, '0},
        '{5'd11, 1'b0, 26'h00007FF, 1'b1, '{31'h00007FFF, 5'd15, 3'd4}},
        '{5'd12, 1'b0, 26'h0000555, 1'b0, '0},
        '{5'd5,  1'b1, 26'h0000015, 1'b0, '0}
    };

    hamming_encoder #(.MAX_DATA_BITS(DATA_W)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_bits    (i_data_bits),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_codeword     (o_codeword),
        .o_code_length  (o_code_length),
        .o_parity_count (o_parity_count)
    );

    always #1 i_clk = ~i_clk;

    // Places the data bits, highest used bit first, then fills in each parity bit.
    function automatic t_code_result hamming_encode(logic [DATA_W-1:0] data,
                                                    logic [4:0] raw_len, logic odd);
        t_code_result res;
        logic [31:0]  code;
        logic         acc;
        int           len;
        int           p;
        int           n;
        int           k;
        int           pos;
        int           ppos;
        len = int'(raw_len);
        if (len < 1) begin
            len = 1;
        end
        if (len > DATA_W) begin
            len = DATA_W;
        end
        p = 0;
        while ((1 << p) < len + p + 1) begin
            p++;
        end
        n = len + p;
        code = '0;
        k = 0;
        for (pos = 1; pos <= n; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
                code[pos-1] = data[len-1-k];
                k++;
            end
        end
        for (int i = 0; i < p; i++) begin
            ppos = 1 << i;
            acc = odd;
            for (pos = 1; pos <= n; pos++) begin
                if ((pos & ppos) != 0 && pos != ppos) begin
                    acc ^= code[pos-1];
                end
            end
            code[ppos-1] = acc;
        end
        res.codeword = code[CODE_W-1:0];
        res.code_length = 5'(n);
        res.parity_count = 3'(p);
        return res;
    endfunction

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Result side: stall generation and checking of every accepted transaction.
    always @(posedge i_clk) begin
        t_code_result want;
        int           len;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_codes.size() == 0) begin
                $display("%0t: unexpected result codeword %h length %0d parity %0d", $time,
                         o_codeword, o_code_length, o_parity_count);
                mismatch_count++;
            end else begin
                want = pending_codes.pop_front();
                if (o_codeword !== want.codeword) begin
                    $display("%0t: codeword expected %h actual %h", $time,
                             want.codeword, o_codeword);
                    mismatch_count++;
                end
                if (o_code_length !== want.code_length) begin
                    $display("%0t: code_length expected %0d actual %0d", $time,
                             want.code_length, o_code_length);
                    mismatch_count++;
                end
                if (o_parity_count !== want.parity_count) begin
                    $display("%0t: parity_count expected %0d actual %0d", $time,
                             want.parity_count, o_parity_count);
                    mismatch_count++;
                end
            end
        end
        if (rx_hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            rx_hold_cycles--;
        end else if (rx_stall_left > 0) begin
            i_out_stall <= 1'b1;
            rx_stall_left--;
        end else if (rx_idle) begin
            len = pick_gap();
            i_out_stall <= (len != 0);
            rx_stall_left = (len > 0) ? len - 1 : 0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic apb_write(logic addr_bit, logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({addr_bit, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until every result is back, lets the pipeline settle, then writes
    // whichever registers differ. Upper data bits are random or zero, as only
    // the low bits of each register are kept.
    task automatic set_config(logic [4:0] len, logic odd);
        i_in_valid <= 1'b0;
        while (pending_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (len != cur_len) begin
            apb_write(REG_DATA_LENGTH, {$urandom_range(0, 1) ? $urandom() : 32'h0} & ~32'h1F | len);
            cur_len = len;
        end
        if (odd != cur_odd) begin
            apb_write(REG_PARITY_ODD, {$urandom_range(0, 1) ? $urandom() : 32'h0} & ~32'h1 | odd);
            cur_odd = odd;
        end
    endtask

    // Called in step with the clock; returns just after the word has been accepted.
    task automatic send_word(logic [DATA_W-1:0] data, int gap, logic typed, t_code_result known);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_bits <= data;
        do @(posedge i_clk); while (o_in_stall);
        pending_codes.push_back(typed ? known : hamming_encode(data, cur_len, cur_odd));
    endtask

    initial begin
        int          sent;
        int          phase;
        int          count;
        bit          tx_idle;
        logic [4:0]  len;
        logic [DATA_W-1:0] data;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].len != cur_len || directed_rows[r].odd != cur_odd) begin
                set_config(directed_rows[r].len, directed_rows[r].odd);
            end
            send_word(directed_rows[r].data, 0, directed_rows[r].typed,
                      directed_rows[r].result);
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: len = 5'd0;
                1: len = 5'd26;
                2: len = 5'd31;
                3: len = 5'd1;
                default: len = 5'($urandom_range(0, 31));
            endcase
            set_config(len, 1'($urandom_range(0, 1)));
            count = $urandom_range(30, 100);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            // One phase holds the result side off for a long time while words keep coming.
            if (phase == 2) begin
                tx_idle = 1'b0;
                rx_hold_cycles = 300;
            end
            for (int i = 0; i < count; i++) begin
                case ($urandom_range(0, 15))
                    0: data = '0;
                    1: data = '1;
                    default: data = DATA_W'($urandom());
                endcase
                send_word(data, tx_idle ? pick_gap() : 0, 1'b0, '0);
            end
            sent += count;
            phase++;
        end
        i_in_valid <= 1'b0;

        while (pending_codes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
